FILE: src/msfd_pkg.sv
// Shared types and constants for the multi-server dispatcher.
`default_nettype none

package msfd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SERVER_COUNT = 2'd0;
    localparam logic [1:0] REG_MAX_SERVICE  = 2'd1;

    localparam logic [4:0]  SERVER_COUNT_RESET = 5'd1;
    localparam logic [15:0] SERVICE_RESET      = 16'd60;
    localparam logic [15:0] JOBS_MAX           = 16'hFFFF;
    localparam logic [31:0] TIME_MAX           = 32'hFFFF_FFFF;

    // One server entry as stored in the server memory
    typedef struct packed {
        logic [15:0] jobs;
        logic [31:0] free_at;
    } ent_t;

    // Control for the scan accumulator
    typedef struct packed {
        logic valid;
        logic first;
    } scan_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

FILE: src/msfd_mem.sv
// Server state memory: free time and job count per server, registered read.
`default_nettype none

module msfd_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire msfd_pkg::ent_t wr_data,
    output msfd_pkg::ent_t     rd_data,
    output logic               rd_valid,
    output logic [IW-1:0]      rd_idx
);

    msfd_pkg::ent_t  mem_ram [DEPTH];
    msfd_pkg::ent_t  rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_hit_reg;
    logic             rd_valid_reg;
    logic [IW-1:0]    rd_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_ram[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    // entry valid bits: cleared on reset and at a batch start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_hit_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (rd_en)
            begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data  = rd_hit_reg ? rd_data_reg : '0;
    assign rd_valid = rd_valid_reg;
    assign rd_idx   = rd_idx_reg;

endmodule

`default_nettype wire

FILE: src/msfd_scan.sv
// Scan accumulator: earliest effective free time, first already-free server, latest free.
`default_nettype none

module msfd_scan #(
    parameter int IW = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire msfd_pkg::scan_ctl_t ctl,
    input  wire logic [IW-1:0]      idx,
    input  wire msfd_pkg::ent_t     ent,
    input  wire logic [31:0]        clock_now,
    input  wire logic [31:0]        arrival,
    output logic [31:0]             min_eff,
    output logic [IW-1:0]           min_idx,
    output logic [15:0]             min_jobs,
    output logic [IW-1:0]           hit_idx,
    output logic [15:0]             hit_jobs,
    output logic [31:0]             max_free
);

    logic [31:0]   min_eff_reg,  min_eff_next;
    logic [IW-1:0] min_idx_reg,  min_idx_next;
    logic [15:0]   min_jobs_reg, min_jobs_next;
    logic          hit_reg,      hit_next;
    logic [IW-1:0] hit_idx_reg,  hit_idx_next;
    logic [15:0]   hit_jobs_reg, hit_jobs_next;
    logic [31:0]   max_free_reg, max_free_next;
    logic [31:0]   eff;
    logic          is_free;

    always_comb
    begin
        eff     = (ent.free_at > clock_now) ? ent.free_at : clock_now;
        is_free = (eff <= arrival);

        min_eff_next  = min_eff_reg;
        min_idx_next  = min_idx_reg;
        min_jobs_next = min_jobs_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_jobs_next = hit_jobs_reg;
        max_free_next = max_free_reg;

        if (ctl.valid)
        begin
            if (ctl.first)
            begin
                min_eff_next  = eff;
                min_idx_next  = idx;
                min_jobs_next = ent.jobs;
                hit_next      = is_free;
                hit_idx_next  = idx;
                hit_jobs_next = ent.jobs;
                max_free_next = ent.free_at;
            end
            else
            begin
                // strict compare keeps the lowest index on ties
                if (eff < min_eff_reg)
                begin
                    min_eff_next  = eff;
                    min_idx_next  = idx;
                    min_jobs_next = ent.jobs;
                end
                if (!hit_reg && is_free)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = idx;
                    hit_jobs_next = ent.jobs;
                end
                if (ent.free_at > max_free_reg)
                begin
                    max_free_next = ent.free_at;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_eff_reg  <= min_eff_next;
        min_idx_reg  <= min_idx_next;
        min_jobs_reg <= min_jobs_next;
        hit_idx_reg  <= hit_idx_next;
        hit_jobs_reg <= hit_jobs_next;
        max_free_reg <= max_free_next;
    end

    assign min_eff  = min_eff_reg;
    assign min_idx  = min_idx_reg;
    assign min_jobs = min_jobs_reg;
    assign hit_idx  = hit_idx_reg;
    assign hit_jobs = hit_jobs_reg;
    assign max_free = max_free_reg;

endmodule

`default_nettype wire

FILE: src/multi_server_fifo_dispatcher_unit.sv
// Top level of the multi-server dispatcher: control, statistics and result register.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  tdata: arrival_time, service_time; tuser: start_batch
//  m_*       out        m_tvalid/m_tready  tdata: server_index .. server_jobs
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// Per item, the scan reads one server entry per cycle for the k servers in use,
// through the single read port of the server memory; then follow the read
// latency, the update state and the idle state in which the next item is accepted.
// The result is registered in the update state and can wait there while the
// next item is accepted. A stalled result holds the update until it is taken.
// Reset clears control, statistics and the entry valid bits at once; no clearing pass.
`default_nettype none

module multi_server_fifo_dispatcher_unit #(
    parameter int MAX_SERVERS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // [31:0] arrival_time, [47:32] service_time
    input  wire logic         s_tuser,   // [0] start_batch
    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,   // [3:0] server_index, [35:4] job_wait,
                                         // [67:36] total_wait, [99:68] longest_wait,
                                         // [131:100] finish_time, [147:132] server_jobs
    // configuration writes
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int KW = $clog2(MAX_SERVERS + 1);

    // configuration
    logic [4:0]  server_count_reg;
    logic [15:0] max_service_reg;

    // item and statistics
    logic [31:0] arrival_reg;
    logic [15:0] service_reg;
    logic [31:0] clock_now_reg,  clock_now_next;
    logic [31:0] wait_sum_reg,   wait_sum_next;
    logic [31:0] wait_peak_reg,  wait_peak_next;

    // control
    msfd_pkg::state_t state_reg, state_next;
    logic [KW-1:0]    iss_reg,   iss_next;
    logic [KW-1:0]    k_eff;
    logic             accept;
    logic             rd_en;
    logic             scan_last;
    logic             upd_go;

    // memory and scan
    msfd_pkg::ent_t      rd_ent;
    msfd_pkg::ent_t      wr_ent;
    logic                rd_valid;
    logic [IW-1:0]       rd_idx;
    msfd_pkg::scan_ctl_t scan_ctl;
    logic [31:0]         min_eff;
    logic [IW-1:0]       min_idx;
    logic [15:0]         min_jobs;
    logic [IW-1:0]       hit_idx;
    logic [15:0]         hit_jobs;
    logic [31:0]         max_free;

    // update datapath
    logic [IW-1:0] chosen;
    logic [15:0]   chosen_jobs;
    logic [15:0]   jobs_new;
    logic [31:0]   start_t;
    logic [31:0]   wait_t;
    logic [32:0]   free_sum;
    logic [31:0]   free_new;
    logic [32:0]   sum_ext;
    logic [31:0]   fin_t;
    logic [7:0]    chosen_ext;
    logic          late;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [3:0]    o_server_reg;
    logic [31:0]   o_wait_reg;
    logic [31:0]   o_total_reg;
    logic [31:0]   o_longest_reg;
    logic [31:0]   o_finish_reg;
    logic [15:0]   o_jobs_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_count_reg <= msfd_pkg::SERVER_COUNT_RESET;
            max_service_reg  <= msfd_pkg::SERVICE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                msfd_pkg::REG_SERVER_COUNT: server_count_reg <= cfg_data[4:0];
                msfd_pkg::REG_MAX_SERVICE:  max_service_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // servers in use: zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (server_count_reg == 5'd0)
        begin
            k_eff = KW'(1);
        end
        else if ({3'b000, server_count_reg} > 8'(MAX_SERVERS))
        begin
            k_eff = KW'(MAX_SERVERS);
        end
        else
        begin
            k_eff = KW'(server_count_reg);
        end
    end

    // ---------------------------------------------------------------- control
    assign scan_last = rd_valid && ((KW'(rd_idx) + KW'(1)) == k_eff);

    always_comb
    begin
        state_next = state_reg;
        iss_next   = iss_reg;
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        upd_go     = 1'b0;
        case (state_reg)
            msfd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                iss_next = '0;
                if (s_tvalid)
                begin
                    state_next = msfd_pkg::ST_SCAN;
                end
            end
            msfd_pkg::ST_SCAN:
            begin
                // one server read per cycle; the accumulator takes each entry in the cycle after its read
                if (iss_reg < k_eff)
                begin
                    rd_en    = 1'b1;
                    iss_next = iss_reg + KW'(1);
                end
                if (scan_last)
                begin
                    state_next = msfd_pkg::ST_UPDATE;
                end
            end
            msfd_pkg::ST_UPDATE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    upd_go     = 1'b1;
                    state_next = msfd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msfd_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msfd_pkg::ST_IDLE;
            iss_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iss_reg   <= iss_next;
        end
    end

    // latch the item; service is clamped on the way in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arrival_reg <= s_tdata[31:0];
            service_reg <= (s_tdata[47:32] > max_service_reg) ? max_service_reg
                                                              : s_tdata[47:32];
        end
    end

    // ---------------------------------------------------------------- memory
    // Writes happen only in the update cycle and reads only during the scan,
    // so the FSM keeps accesses to one entry from overlapping.
    msfd_mem #(
        .DEPTH (MAX_SERVERS),
        .IW    (IW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept && s_tuser),
        .rd_en    (rd_en),
        .rd_addr  (iss_reg[IW-1:0]),
        .wr_en    (upd_go),
        .wr_addr  (chosen),
        .wr_data  (wr_ent),
        .rd_data  (rd_ent),
        .rd_valid (rd_valid),
        .rd_idx   (rd_idx)
    );

    assign scan_ctl.valid = rd_valid;
    assign scan_ctl.first = (rd_idx == '0);

    msfd_scan #(
        .IW (IW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .idx       (rd_idx),
        .ent       (rd_ent),
        .clock_now (clock_now_reg),
        .arrival   (arrival_reg),
        .min_eff   (min_eff),
        .min_idx   (min_idx),
        .min_jobs  (min_jobs),
        .hit_idx   (hit_idx),
        .hit_jobs  (hit_jobs),
        .max_free  (max_free)
    );

    // ---------------------------------------------------------------- update
    // Earliest free at or after arrival: start there and wait. Otherwise start at
    // arrival on the first server already free (one exists since the minimum is).
    always_comb
    begin
        late = (min_eff >= arrival_reg);
        if (late)
        begin
            chosen      = min_idx;
            chosen_jobs = min_jobs;
            start_t     = min_eff;
            wait_t      = min_eff - arrival_reg;
        end
        else
        begin
            chosen      = hit_idx;
            chosen_jobs = hit_jobs;
            start_t     = arrival_reg;
            wait_t      = '0;
        end

        free_sum = {1'b0, start_t} + {17'd0, service_reg};
        free_new = free_sum[32] ? msfd_pkg::TIME_MAX : free_sum[31:0];
        jobs_new = (chosen_jobs == msfd_pkg::JOBS_MAX) ? chosen_jobs
                                                       : chosen_jobs + 16'd1;
        wr_ent.free_at = free_new;
        wr_ent.jobs    = jobs_new;

        // the old free time of the chosen server never exceeds start
        fin_t = (max_free > free_new) ? max_free : free_new;

        sum_ext        = {1'b0, wait_sum_reg} + {1'b0, wait_t};
        wait_sum_next  = sum_ext[32] ? msfd_pkg::TIME_MAX : sum_ext[31:0];
        wait_peak_next = (wait_t > wait_peak_reg) ? wait_t : wait_peak_reg;
        clock_now_next = start_t;
        chosen_ext     = 8'(chosen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_now_reg <= '0;
            wait_sum_reg  <= '0;
            wait_peak_reg <= '0;
        end
        else if (accept && s_tuser)
        begin
            clock_now_reg <= '0;
            wait_sum_reg  <= '0;
            wait_peak_reg <= '0;
        end
        else if (upd_go)
        begin
            clock_now_reg <= clock_now_next;
            wait_sum_reg  <= wait_sum_next;
            wait_peak_reg <= wait_peak_next;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go)
        begin
            o_server_reg  <= chosen_ext[3:0];
            o_wait_reg    <= wait_t;
            o_total_reg   <= wait_sum_next;
            o_longest_reg <= wait_peak_next;
            o_finish_reg  <= fin_t;
            o_jobs_reg    <= jobs_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, o_jobs_reg, o_finish_reg, o_longest_reg,
                       o_total_reg, o_wait_reg, o_server_reg};

`ifndef ASSERT_OFF
    // the dispatched server lies among the servers in use
    a_chosen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |-> (KW'(chosen) < k_eff))
        else $error("dispatched server outside the servers in use");

    // one item at a time: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // running statistics never fall below the wait they include
    a_stats_cover_wait: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((o_total_reg >= o_wait_reg) && (o_longest_reg >= o_wait_reg)))
        else $error("wait statistics below the job wait");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the multi-server FIFO dispatcher unit.

module tb;

    localparam int SERVERS = 16;
    // Indexes with no register behind them; writes there must be ignored.
    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;
    localparam int GAP_PCT = 18;        // idle chance per cycle on either side, percent
    localparam int SETTLE_CYCLES = 40;  // outlasts one item in flight for k = 16

    // One result item, field for field as the block reports it.
    typedef struct packed {
        logic [3:0]  server_index;
        logic [31:0] job_wait;
        logic [31:0] total_wait;
        logic [31:0] longest_wait;
        logic [31:0] finish_time;
        logic [15:0] server_jobs;
    } job_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;   // [31:0] arrival_time, [47:32] service_time
    logic         s_tuser = 1'b0; // [0] start_batch
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;        // [3:0] server_index, [35:4] job_wait, [67:36] total_wait,
                                  // [99:68] longest_wait, [131:100] finish_time,
                                  // [147:132] server_jobs
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    // Dispatcher shadow: server table, batch statistics and register copies.
    logic [31:0] free_at [SERVERS];
    logic [15:0] job_count [SERVERS];
    logic [31:0] wait_total;
    logic [31:0] wait_max;
    logic [31:0] last_start;
    logic [4:0]  cfg_servers;
    logic [15:0] cfg_svc_cap;

    job_result_t expected_results[$];
    job_result_t want;

    bit no_gaps = 1'b0;       // set for the stretch with no idling on either side
    int fail_count = 0;
    int results_checked = 0;
    int jobs_sent = 0;
    int batches = 0;
    int settings_used = 0;

    multi_server_fifo_dispatcher_unit #(
        .MAX_SERVERS(SERVERS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side back-pressure: random stalls except in the gap-free stretch.
    always @(posedge clk)
        m_tready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);

    // ------------------------------------------------------------------
    // Shadow model of the dispatcher
    // ------------------------------------------------------------------

    function automatic void clear_server_state();
        for (int i = 0; i < SERVERS; i++)
        begin
            free_at[i] = '0;
            job_count[i] = '0;
        end
        wait_total = '0;
        wait_max = '0;
        last_start = '0;
    endfunction

    // A server never counts as free before the previous start.
    function automatic logic [31:0] free_time(int idx);
        return (free_at[idx] > last_start) ? free_at[idx] : last_start;
    endfunction

    // Out-of-range counts fold to 1 or to the server limit.
    function automatic int servers_in_use();
        if (cfg_servers == 0)
            return 1;
        if (cfg_servers > SERVERS)
            return SERVERS;
        return int'(cfg_servers);
    endfunction

    // Earliest-free dispatch of one job; updates the shadow and returns its result.
    function automatic job_result_t dispatch_job(logic [31:0] arrival, logic [15:0] svc_req,
                                                 logic new_batch);
        job_result_t r;
        int k;
        int pick;
        bit found;
        logic [31:0] svc;
        logic [31:0] m;
        logic [31:0] begin_at;
        logic [31:0] waited;
        logic [31:0] fin;
        logic [32:0] sum;
        if (new_batch)
            clear_server_state();
        svc = (svc_req > cfg_svc_cap) ? {16'd0, cfg_svc_cap} : {16'd0, svc_req};
        k = servers_in_use();
        pick = 0;
        m = free_time(0);
        for (int i = 1; i < k; i++)
        begin
            if (free_time(i) < m)
            begin
                m = free_time(i);
                pick = i;
            end
        end
        if (m >= arrival)
        begin
            begin_at = m;
            waited = m - arrival;
        end
        else
        begin
            // some server is idle already: lowest index among them, no wait
            begin_at = arrival;
            waited = '0;
            found = 1'b0;
            for (int i = 0; i < k; i++)
            begin
                if (!found && free_time(i) <= arrival)
                begin
                    pick = i;
                    found = 1'b1;
                end
            end
        end
        last_start = begin_at;
        sum = {1'b0, begin_at} + {1'b0, svc};
        free_at[pick] = sum[32] ? msfd_pkg::TIME_MAX : sum[31:0];
        if (job_count[pick] < msfd_pkg::JOBS_MAX)
            job_count[pick] = job_count[pick] + 16'd1;
        sum = {1'b0, wait_total} + {1'b0, waited};
        wait_total = sum[32] ? msfd_pkg::TIME_MAX : sum[31:0];
        if (waited > wait_max)
            wait_max = waited;
        fin = last_start;
        for (int i = 0; i < k; i++)
        begin
            if (free_time(i) > fin)
                fin = free_time(i);
        end
        r.server_index = pick[3:0];
        r.job_wait = waited;
        r.total_wait = wait_total;
        r.longest_wait = wait_max;
        r.finish_time = fin;
        r.server_jobs = job_count[pick];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Every accepted result is held against the oldest pending job.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no job pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("server_index", 32'(want.server_index), 32'(m_tdata[3:0]));
                check_field("job_wait", want.job_wait, m_tdata[35:4]);
                check_field("total_wait", want.total_wait, m_tdata[67:36]);
                check_field("longest_wait", want.longest_wait, m_tdata[99:68]);
                check_field("finish_time", want.finish_time, m_tdata[131:100]);
                check_field("server_jobs", 32'(want.server_jobs), 32'(m_tdata[147:132]));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one job; valid stays high into the next job unless a gap is drawn,
    // so it is never dropped and raised in the same step.
    task automatic send_job(input logic [31:0] arrival, input logic [15:0] svc,
                            input logic new_batch);
        while (!no_gaps && $urandom_range(0, 99) < GAP_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {svc, arrival};
        s_tuser <= new_batch;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(dispatch_job(arrival, svc, new_batch));
        jobs_sent++;
    endtask

    // Stop offering jobs until every pending result has been taken.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            msfd_pkg::REG_SERVER_COUNT: cfg_servers = data[4:0];
            msfd_pkg::REG_MAX_SERVICE:  cfg_svc_cap = data;
            default:                    ;
        endcase
    endtask

    // Registers change only with the block idle and no result outstanding.
    task automatic apply_settings(input logic [15:0] count_data, input logic [15:0] cap);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(msfd_pkg::REG_SERVER_COUNT, count_data);
        write_reg(msfd_pkg::REG_MAX_SERVICE, cap);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: one server, service clamped at 60.
    task automatic test_reset_defaults();
        send_job(32'd0, 16'd100, 1'b0);
        send_job(32'd10, 16'd0, 1'b0);
        send_job(32'd200, 16'hFFFF, 1'b0);
        send_job(32'd500, 16'd60, 1'b1);
    endtask

    task automatic test_field_extremes();
        apply_settings(16'd3, 16'hFFFF);
        send_job(32'd0, 16'd0, 1'b1);
        send_job(32'd0, 16'hFFFF, 1'b0);
        send_job(32'd0, 16'hFFFF, 1'b0);
        send_job(32'd0, 16'hFFFF, 1'b0);   // third server still free at 0: no wait
        // free time overflow saturates at the top of the time range
        send_job(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_job(32'hFFFF_FFFF, 16'd1, 1'b0);
        // arrival before the previous start: held until that start at least
        send_job(32'd1000, 16'd10, 1'b1);
        send_job(32'd5, 16'd10, 1'b0);
    endtask

    // Two waits of all ones push the running total into saturation.
    task automatic test_wait_saturation();
        apply_settings(16'd1, 16'hFFFF);
        send_job(32'hFFFF_FFF0, 16'hFFFF, 1'b1);
        send_job(32'd0, 16'd0, 1'b0);
        send_job(32'd0, 16'd0, 1'b0);
        send_job(32'd0, 16'd0, 1'b0);
    endtask

    task automatic test_server_count_edges();
        // count 0 acts as one server; a zero ceiling zeroes every service time
        apply_settings(16'd0, 16'd0);
        send_job(32'd0, 16'd500, 1'b1);
        send_job(32'd7, 16'hFFFF, 1'b0);
        // count above the limit acts as the limit; upper data bits are dropped
        apply_settings(16'hFFFF, 16'd60);
        send_job(32'd0, 16'd100, 1'b1);
        send_job(32'd0, 16'd100, 1'b0);
        // servers outside the count keep their state while left out
        apply_settings(16'd4, 16'd50);
        send_job(32'd0, 16'd50, 1'b1);
        send_job(32'd0, 16'd50, 1'b0);
        send_job(32'd0, 16'd50, 1'b0);
        send_job(32'd0, 16'd50, 1'b0);
        apply_settings(16'hFFE2, 16'd50);  // low five bits give two servers
        send_job(32'd10, 16'd50, 1'b0);
        apply_settings(16'd4, 16'd50);
        send_job(32'd20, 16'd50, 1'b0);
        send_job(32'd20, 16'd50, 1'b0);
    endtask

    task automatic test_unknown_index();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0003);
        send_job(32'd0, 16'd100, 1'b1);
        send_job(32'd0, 16'd100, 1'b0);
    endtask

    // Mostly batches with nondecreasing arrivals paced near full load, so that
    // queues build up and drain; the rest is random or backward arrivals.
    task automatic run_random_phase(input int n_jobs, input logic [15:0] count_data,
                                    input logic [15:0] cap, input bit pause_midway);
        logic [31:0] arrival;
        logic [15:0] svc;
        bit new_batch;
        int unsigned svc_hi;
        int unsigned incr_hi;
        int unsigned top_span;
        apply_settings(count_data, cap);
        svc_hi = (cap == 0) ? 100 : int'(cap) + int'(cap) / 4 + 1;
        if (svc_hi > 65535)
            svc_hi = 65535;
        incr_hi = int'(cap) / servers_in_use() + 2;
        top_span = 4 * int'(cap) + 64;
        arrival = '0;
        for (int i = 0; i < n_jobs; i++)
        begin
            if (pause_midway && i == n_jobs / 2)
                wait_results_drained();
            new_batch = (i == 0) || ($urandom_range(0, 39) == 0);
            if (new_batch)
            begin
                case ($urandom_range(0, 2))
                    0:       arrival = '0;
                    1:       arrival = $urandom;
                    default: arrival = msfd_pkg::TIME_MAX - $urandom_range(0, top_span);
                endcase
                batches++;
            end
            else if ($urandom_range(0, 99) < 88)
                arrival = arrival + $urandom_range(0, incr_hi);
            else if ($urandom_range(0, 1) == 0)
                arrival = $urandom;
            else
                arrival = arrival - $urandom_range(0, incr_hi);
            if ($urandom_range(0, 4) == 0)
                svc = 16'($urandom);
            else
                svc = 16'($urandom_range(0, svc_hi));
            send_job(arrival, svc, new_batch);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(220, 16'd1, 16'd60, 1'b0);
        run_random_phase(220, 16'd16, 16'hFFFF, 1'b1);
        run_random_phase(220, 16'd0, 16'd1, 1'b0);
        run_random_phase(220, 16'h001F, 16'd0, 1'b0);
        run_random_phase(220, 16'($urandom_range(2, 15)), 16'($urandom_range(1, 65535)), 1'b0);
        run_random_phase(220, 16'd16, 16'd200, 1'b1);
        no_gaps = 1'b1;
        run_random_phase(220, 16'd2, 16'hFFFF, 1'b0);
        no_gaps = 1'b0;
        run_random_phase(220, 16'($urandom), 16'($urandom_range(1, 65535)), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        cfg_servers = msfd_pkg::SERVER_COUNT_RESET;
        cfg_svc_cap = msfd_pkg::SERVICE_RESET;
        clear_server_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_wait_saturation();
        test_server_count_edges();
        test_unknown_index();
        test_random_traffic();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Dispatched %0d jobs in %0d batches under %0d register settings;",
                 jobs_sent, batches, settings_used);
        $display("%0d result items compared field by field, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("multi_server_fifo_dispatcher_unit verification clean");
        else
            $display("multi_server_fifo_dispatcher_unit verification failed");
        $finish;
    end

    // Run guard, many times the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("multi_server_fifo_dispatcher_unit verification failed");
        $finish;
    end

endmodule
